// ----- rtl/core/nearest_center_stencil_select_assert.svh -----
// assertion macros shared by the stencil select rtl
`ifndef NEAREST_CENTER_STENCIL_SELECT_ASSERT_SVH
`define NEAREST_CENTER_STENCIL_SELECT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NCSS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define NCSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ncss_pkg.sv -----
package ncss_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIST_BITS  = 2 * COORD_BITS + 2;
    localparam int INDEX_BITS = 8;
    localparam int SQ_BITS    = 2 * COORD_BITS + 1;

    // operation codes
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // configuration register indexes
    typedef enum logic {
        REG_DIMENSIONS = 1'b0,
        REG_NEIGHBORS  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]                   operation;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] neighbor_index;
        logic [DIST_BITS-1:0]  distance_sq;
        logic                  short_list;
        logic                  none_found;
        logic                  last;
    } out_item_t;

    // one stored center
    typedef struct packed {
        logic signed [COORD_BITS-1:0] z;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } coord3_t;

    // one entry of the best list
    typedef struct packed {
        logic [INDEX_BITS-1:0] idx;
        logic [DIST_BITS-1:0]  dsq;
    } entry_t;

    // candidate handed from the distance unit to the best list
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } cand_t;

endpackage

// ----- rtl/core/ncss_dist_unit.sv -----
module ncss_dist_unit import ncss_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic [INDEX_BITS-1:0] in_idx,
    input  coord3_t               basis,
    input  coord3_t               query,
    input  logic [1:0]            dims,
    output logic                  busy,
    output cand_t                 cand
);

    logic signed [COORD_BITS:0]     dx, dy, dz;
    logic signed [2*COORD_BITS+1:0] px, py, pz;
    logic [SQ_BITS-1:0]             sq_x_reg, sq_y_reg, sq_z_reg;
    logic                           sq_v_reg;
    logic [INDEX_BITS-1:0]          sq_idx_reg;

    // per-axis difference and square
    always_comb begin
        dx = $signed({basis.x[COORD_BITS-1], basis.x}) - $signed({query.x[COORD_BITS-1], query.x});
        dy = $signed({basis.y[COORD_BITS-1], basis.y}) - $signed({query.y[COORD_BITS-1], query.y});
        dz = $signed({basis.z[COORD_BITS-1], basis.z}) - $signed({query.z[COORD_BITS-1], query.z});
        px = dx * dx;
        py = dy * dy;
        pz = dz * dz;
    end

    // square stage, unused axes drop out
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg <= 1'b0;
        end else begin
            sq_v_reg <= in_valid;
        end
        sq_idx_reg <= in_idx;
        sq_x_reg   <= px[SQ_BITS-1:0];
        sq_y_reg   <= (dims >= 2'd2) ? py[SQ_BITS-1:0] : '0;
        sq_z_reg   <= (dims == 2'd3) ? pz[SQ_BITS-1:0] : '0;
    end

    // sum stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand.valid <= 1'b0;
        end else begin
            cand.valid <= sq_v_reg;
        end
        cand.entry.idx <= sq_idx_reg;
        cand.entry.dsq <= DIST_BITS'(sq_x_reg) + DIST_BITS'(sq_y_reg) + DIST_BITS'(sq_z_reg);
    end

    assign busy = sq_v_reg;

endmodule

// ----- rtl/core/ncss_best_list.sv -----
module ncss_best_list import ncss_pkg::*; #(
    parameter int MAX_NEIGHBORS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [$clog2(MAX_NEIGHBORS+1)-1:0]   k,
    input  cand_t                                cand,
    input  logic                                 pop,
    output entry_t                               head,
    output logic [$clog2(MAX_NEIGHBORS+1)-1:0]   filled
);

    localparam int KW = $clog2(MAX_NEIGHBORS + 1);

    entry_t          cell_reg [MAX_NEIGHBORS];
    logic [KW-1:0]   filled_reg;
    logic [MAX_NEIGHBORS-1:0] after;

    // cells at or past the insertion point
    always_comb begin
        for (int i = 0; i < MAX_NEIGHBORS; i++) begin
            after[i] = (KW'(i) >= filled_reg) || (cell_reg[i].dsq > cand.entry.dsq);
        end
    end

    // sorted row: insert with shift up, pop with shift down
    for (genvar g = 0; g < MAX_NEIGHBORS; g++) begin : g_cell
        always_ff @(posedge aclk) begin
            if (pop) begin
                if (g < MAX_NEIGHBORS - 1) begin
                    cell_reg[g] <= cell_reg[(g < MAX_NEIGHBORS - 1) ? g + 1 : g];
                end
            end else if (cand.valid && (KW'(g) < k) && after[g]) begin
                if (g > 0 && after[(g > 0) ? g - 1 : 0]) begin
                    cell_reg[g] <= cell_reg[(g > 0) ? g - 1 : 0];
                end else begin
                    cell_reg[g] <= cand.entry;
                end
            end
        end
    end

    // fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg <= '0;
        end else if (start) begin
            filled_reg <= '0;
        end else if (pop) begin
            filled_reg <= filled_reg - 1'b1;
        end else if (cand.valid && filled_reg < k) begin
            filled_reg <= filled_reg + 1'b1;
        end
    end

    assign head   = cell_reg[0];
    assign filled = filled_reg;

endmodule

// ----- rtl/core/nearest_center_stencil_select.sv -----
// load and clear: taken while idle, ready again the next cycle
// query over N stored centers: one center read per cycle from the store port,
// then after the drain one result per cycle unless m_ready holds off the output
// (min(K, N) results, or one when the store is empty); next item taken after the last
// synchronous active-low reset clears the fill count, scan and output control,
// sets dimensions to 2 and neighbors_wanted to 6; store contents are kept
`include "nearest_center_stencil_select_assert.svh"

module nearest_center_stencil_select import ncss_pkg::*; #(
    parameter int MAX_BASIS     = 256,
    parameter int MAX_NEIGHBORS = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [5:0] cfg_wdata
);

    localparam int AW   = $clog2(MAX_BASIS);
    localparam int CW   = $clog2(MAX_BASIS + 1);
    localparam int KW   = $clog2(MAX_NEIGHBORS + 1);
    localparam int CMPW = (CW > KW) ? CW : KW;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_EMPTY = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [1:0]      dims_reg;
    logic [5:0]      nw_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   scan_reg;
    logic [KW-1:0]   k_reg;
    logic [KW-1:0]   k_eff;
    logic            short_reg;
    logic [1:0]      dq_reg;
    coord3_t         query_reg;
    coord3_t         basis_mem [MAX_BASIS];
    coord3_t         rd_data_reg;
    logic            rd_v_reg;
    logic [INDEX_BITS-1:0] rd_idx_reg;
    logic            s_fire;
    logic            out_free;
    logic            pop;
    logic            dist_busy;
    cand_t           cand;
    entry_t          best_head;
    logic [KW-1:0]   best_filled;
    logic            m_valid_reg;
    out_item_t       m_data_reg;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign pop      = (state_reg == ST_EMIT) && out_free;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg <= 2'd2;
            nw_reg   <= 6'd6;
        end else if (cfg_we) begin
            if (cfg_index == REG_DIMENSIONS) begin
                dims_reg <= cfg_wdata[1:0];
            end else begin
                nw_reg <= cfg_wdata;
            end
        end
    end

    // neighbor count clamped to one..MAX_NEIGHBORS
    always_comb begin
        if (nw_reg == '0) begin
            k_eff = KW'(1);
        end else if (7'(nw_reg) > 7'(MAX_NEIGHBORS)) begin
            k_eff = KW'(MAX_NEIGHBORS);
        end else begin
            k_eff = KW'(nw_reg);
        end
    end

    // query setup, fill count and scan position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            scan_reg  <= '0;
            k_reg     <= KW'(1);
            short_reg <= 1'b0;
            dq_reg    <= 2'd1;
        end else begin
            if (s_fire) begin
                case (s_data.operation)
                    OP_LOAD: begin
                        if (count_reg < CW'(MAX_BASIS)) begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        count_reg <= '0;
                    end
                    OP_QUERY: begin
                        scan_reg  <= '0;
                        k_reg     <= k_eff;
                        short_reg <= CMPW'(count_reg) < CMPW'(k_eff);
                        dq_reg    <= (dims_reg == 2'd0) ? 2'd1 : dims_reg;
                    end
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_SCAN) begin
                scan_reg <= scan_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_data.operation == OP_QUERY) begin
            query_reg <= '{z: s_data.coord_z, y: s_data.coord_y, x: s_data.coord_x};
        end
    end

    // basis store: append on load, one read per scan cycle
    // coordinates beyond the dimensions in force at load time are stored as zero
    always_ff @(posedge aclk) begin
        if (s_fire && s_data.operation == OP_LOAD && count_reg < CW'(MAX_BASIS)) begin
            basis_mem[count_reg[AW-1:0]] <= '{z: (dims_reg == 2'd3) ? s_data.coord_z : '0,
                                               y: (dims_reg >= 2'd2) ? s_data.coord_y : '0,
                                               x: s_data.coord_x};
        end
        rd_data_reg <= basis_mem[scan_reg[AW-1:0]];
        rd_idx_reg  <= INDEX_BITS'(scan_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg <= 1'b0;
        end else begin
            rd_v_reg <= (state_reg == ST_SCAN);
        end
    end

    ncss_dist_unit u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rd_v_reg),
        .in_idx   (rd_idx_reg),
        .basis    (rd_data_reg),
        .query    (query_reg),
        .dims     (dq_reg),
        .busy     (dist_busy),
        .cand     (cand)
    );

    ncss_best_list #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_best (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_fire && s_data.operation == OP_QUERY),
        .k       (k_reg),
        .cand    (cand),
        .pop     (pop),
        .head    (best_head),
        .filled  (best_filled)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_data.operation == OP_QUERY) begin
                    state_next = (count_reg == '0) ? ST_EMPTY : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_reg == CW'(count_reg - 1'b1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_v_reg && !dist_busy && !cand.valid) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && best_filled == KW'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop || (state_reg == ST_EMPTY && out_free)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg.neighbor_index <= best_head.idx;
            m_data_reg.distance_sq    <= best_head.dsq;
            m_data_reg.short_list     <= short_reg;
            m_data_reg.none_found     <= 1'b0;
            m_data_reg.last           <= (best_filled == KW'(1));
        end else if (state_reg == ST_EMPTY && out_free) begin
            m_data_reg.neighbor_index <= '0;
            m_data_reg.distance_sq    <= '0;
            m_data_reg.short_list     <= 1'b0;
            m_data_reg.none_found     <= 1'b1;
            m_data_reg.last           <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `NCSS_ASSERT_SAME(a_fill_bound, 1'b1, best_filled <= k_reg, "best list overfilled")
    `NCSS_ASSERT_SAME(a_none_last, m_valid_reg && m_data_reg.none_found, m_data_reg.last, "empty result not last")
    `NCSS_ASSERT_NEXT(a_drain_emit, state_reg == ST_DRAIN && !rd_v_reg && !dist_busy && !cand.valid, state_reg == ST_EMIT && best_filled != '0, "drain ended with empty list")
    `NCSS_ASSERT_NEXT(a_empty_query, s_fire && s_data.operation == OP_QUERY && count_reg == '0, state_reg == ST_EMPTY, "empty store query missed")

endmodule
